// File: sv/ezr_pkg.sv
// ----------------------------------------------------------------------------
// ezr_pkg: shared types and constants for the Euler-to-matrix converter
// Request structs, CORDIC constants and the arctangent table.
// ----------------------------------------------------------------------------
package ezr_pkg;

  localparam int unsigned ATAN_ENTRIES = 24;
  localparam int unsigned CORDIC_ITERS_DEF = 16;
  localparam int unsigned ZW = 34;   // Q30 angle width after fold
  localparam int unsigned XW = 34;   // Q30 x/y width
  localparam int unsigned SCW = 22;  // Q20 sin/cos width
  localparam logic [3:0] ORDER_ZYX = 4'd0;

  localparam logic signed [ZW-1:0] PI_Q30      = 34'sd3373259426;
  localparam logic signed [ZW-1:0] HALF_PI_Q30 = 34'sd1686629713;
  localparam logic signed [XW-1:0] GAIN_Q30    = 34'sd652032874;

  typedef struct packed {
    logic signed [15:0] roll_angle;
    logic signed [15:0] pitch_angle;
    logic signed [15:0] yaw_angle;
    logic [3:0]         order_code;
  } in_req_t;

  typedef struct packed {
    logic signed [15:0] m00;
    logic signed [15:0] m01;
    logic signed [15:0] m02;
    logic signed [15:0] m10;
    logic signed [15:0] m11;
    logic signed [15:0] m12;
    logic signed [15:0] m20;
    logic signed [15:0] m21;
    logic signed [15:0] m22;
    logic               result_valid;
  } out_req_t;

  // One CORDIC lane: rotation state of one angle.
  typedef struct packed {
    logic signed [XW-1:0] x;
    logic signed [XW-1:0] y;
    logic signed [ZW-1:0] z;
    logic                 flip;
  } lane_t;

  // Everything one cell hands to its neighbor.
  typedef struct packed {
    logic            vld;
    logic            ok;
    lane_t [2:0]     ln;
  } cell_data_t;

  function automatic logic signed [ZW-1:0] atan_q30(input int unsigned i);
    logic [31:0] t;
    case (i)
      0: t = 32'h3243F6A8;  1: t = 32'h1DAC6705;  2: t = 32'h0FADBAFC;
      3: t = 32'h07F56EA6;  4: t = 32'h03FEAB76;  5: t = 32'h01FFD55B;
      6: t = 32'h00FFFAAA;  7: t = 32'h007FFF55;  8: t = 32'h003FFFEA;
      9: t = 32'h001FFFFD;  10: t = 32'h000FFFFF; 11: t = 32'h0007FFFF;
      12: t = 32'h0003FFFF; 13: t = 32'h0001FFFF; 14: t = 32'h0000FFFF;
      15: t = 32'h00007FFF; 16: t = 32'h00003FFF; 17: t = 32'h00001FFF;
      18: t = 32'h00000FFF; 19: t = 32'h000007FF; 20: t = 32'h000003FF;
      21: t = 32'h000001FF; 22: t = 32'h000000FF; 23: t = 32'h0000007F;
      default: t = 32'h0;
    endcase
    return $signed({2'b00, t});
  endfunction

endpackage

// File: sv/ezr_cell.sv
// ----------------------------------------------------------------------------
// ezr_cell: one CORDIC micro-rotation stage
// Rotates the three angle lanes by one table step and registers the result.
// ----------------------------------------------------------------------------
module ezr_cell #(
  parameter int unsigned STEP = 0
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   en,
  input  ezr_pkg::cell_data_t    d_in,
  output ezr_pkg::cell_data_t    d_out
);
  import ezr_pkg::*;

  localparam logic signed [ZW-1:0] ATAN = atan_q30(STEP);

  cell_data_t data_r, data_nxt;

  // Micro-rotation on each lane; shifts are arithmetic.
  always_comb begin
    data_nxt = d_in;
    for (int k = 0; k < 3; k++) begin
      if (!d_in.ln[k].z[ZW-1]) begin
        data_nxt.ln[k].x = d_in.ln[k].x - (d_in.ln[k].y >>> STEP);
        data_nxt.ln[k].y = d_in.ln[k].y + (d_in.ln[k].x >>> STEP);
        data_nxt.ln[k].z = d_in.ln[k].z - ATAN;
      end else begin
        data_nxt.ln[k].x = d_in.ln[k].x + (d_in.ln[k].y >>> STEP);
        data_nxt.ln[k].y = d_in.ln[k].y - (d_in.ln[k].x >>> STEP);
        data_nxt.ln[k].z = d_in.ln[k].z + ATAN;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      data_r.vld <= 1'b0;
    end else if (en) begin
      data_r.vld <= d_in.vld;
    end
    if (en) begin
      data_r.ok <= data_nxt.ok;
      data_r.ln <= data_nxt.ln;
    end
  end

  assign d_out = data_r;

endmodule

// File: sv/ezr_matrix.sv
// ----------------------------------------------------------------------------
// ezr_matrix: sine/cosine rounding and matrix product pipeline
// Rounds CORDIC outputs to Q20, forms products and sums, converts and saturates.
// ----------------------------------------------------------------------------
module ezr_matrix (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 en,
  input  ezr_pkg::cell_data_t  d_in,
  output logic                 vld,
  output ezr_pkg::out_req_t    res
);
  import ezr_pkg::*;

  typedef logic signed [SCW-1:0] sc_t;
  typedef logic signed [2*SCW-1:0] p40_t;
  typedef logic signed [67:0] p60_t;
  typedef logic signed [2*SCW-22:0] hi_t;

  // Stage A: rounded sin/cos.
  logic s1_vld_r, s1_ok_r;
  sc_t  sr_r, cr_r, sp_r, cp_r, sy_r, cy_r;
  // Stage B: two-factor products.
  logic s2_vld_r, s2_ok_r;
  p40_t cycp_r, sycp_r, cpsr_r, cpcr_r, sycr_r, sysr_r, cycr_r, cysr_r, cysp_r, sysp_r;
  sc_t  sr2_r, cr2_r, sp2_r;
  // Stage C: entry sums in Q60.
  logic s3_vld_r, s3_ok_r;
  p60_t e_r [9];
  // Stage D: output.
  logic s4_vld_r;
  out_req_t res_r;

  function automatic sc_t rnd(input logic signed [XW-1:0] v, input logic f);
    logic signed [XW:0] t;
    t = f ? -{v[XW-1], v} : {v[XW-1], v};
    t = t + (XW+1)'(512);
    return sc_t'(t >>> 10);
  endfunction

  function automatic logic signed [15:0] to_q14(input p60_t v);
    p60_t r;
    r = (v + (p60_t'(1) <<< 45)) >>> 46;
    if (r > p60_t'(16384)) r = p60_t'(16384);
    if (r < -p60_t'(16384)) r = -p60_t'(16384);
    return r[15:0];
  endfunction

  // Q40 times Q20, split at bit 21 into two narrow partial products.
  function automatic p60_t mul3(input p40_t ab, input sc_t c);
    hi_t  hi;
    sc_t  lo;
    p40_t pl;
    logic signed [2*SCW:0] ph;
    hi = hi_t'(ab >>> 21);
    lo = $signed({1'b0, ab[20:0]});
    ph = hi * c;
    pl = lo * c;
    return (p60_t'(ph) <<< 21) + p60_t'(pl);
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      s2_vld_r <= 1'b0;
      s3_vld_r <= 1'b0;
      s4_vld_r <= 1'b0;
    end else if (en) begin
      s1_vld_r <= d_in.vld;
      s2_vld_r <= s1_vld_r;
      s3_vld_r <= s2_vld_r;
      s4_vld_r <= s3_vld_r;
    end
    if (en) begin
      // Round the three lanes.
      s1_ok_r <= d_in.ok;
      sr_r <= rnd(d_in.ln[0].y, d_in.ln[0].flip);
      cr_r <= rnd(d_in.ln[0].x, d_in.ln[0].flip);
      sp_r <= rnd(d_in.ln[1].y, d_in.ln[1].flip);
      cp_r <= rnd(d_in.ln[1].x, d_in.ln[1].flip);
      sy_r <= rnd(d_in.ln[2].y, d_in.ln[2].flip);
      cy_r <= rnd(d_in.ln[2].x, d_in.ln[2].flip);
      // Pairwise products.
      s2_ok_r <= s1_ok_r;
      cycp_r <= cy_r * cp_r;  sycp_r <= sy_r * cp_r;
      cpsr_r <= cp_r * sr_r;  cpcr_r <= cp_r * cr_r;
      sycr_r <= sy_r * cr_r;  sysr_r <= sy_r * sr_r;
      cycr_r <= cy_r * cr_r;  cysr_r <= cy_r * sr_r;
      cysp_r <= cy_r * sp_r;  sysp_r <= sy_r * sp_r;
      sr2_r <= sr_r; cr2_r <= cr_r; sp2_r <= sp_r;
      // Third factor and sums in Q60.
      s3_ok_r <= s2_ok_r;
      e_r[0] <= p60_t'(cycp_r) <<< 20;
      e_r[1] <= mul3(cysp_r, sr2_r) - (p60_t'(sycr_r) <<< 20);
      e_r[2] <= mul3(cysp_r, cr2_r) + (p60_t'(sysr_r) <<< 20);
      e_r[3] <= p60_t'(sycp_r) <<< 20;
      e_r[4] <= mul3(sysp_r, sr2_r) + (p60_t'(cycr_r) <<< 20);
      e_r[5] <= mul3(sysp_r, cr2_r) - (p60_t'(cysr_r) <<< 20);
      e_r[6] <= -(p60_t'(sp2_r) <<< 40);
      e_r[7] <= p60_t'(cpsr_r) <<< 20;
      e_r[8] <= p60_t'(cpcr_r) <<< 20;
      // Convert, saturate, and zero rejected requests.
      if (s3_ok_r) begin
        res_r <= '{to_q14(e_r[0]), to_q14(e_r[1]), to_q14(e_r[2]),
                   to_q14(e_r[3]), to_q14(e_r[4]), to_q14(e_r[5]),
                   to_q14(e_r[6]), to_q14(e_r[7]), to_q14(e_r[8]), 1'b1};
      end else begin
        res_r <= '0;
      end
    end
  end

  assign vld = s4_vld_r;
  assign res = res_r;

endmodule

// File: sv/euler_zyx_to_rotation_matrix.sv
// ----------------------------------------------------------------------------
// euler_zyx_to_rotation_matrix: ZYX Euler angles to direction cosine matrix
// Top level: angle fold, a chain of CORDIC cells, and the product pipeline.
// ----------------------------------------------------------------------------
// Usage:
// A request on the in_ channel carries roll, pitch and yaw (Q3.13 radians)
// and an order code. The out_ channel returns one request holding the nine
// Q2.14 matrix entries and a valid flag; a non-ZYX order code returns zeros
// with the flag clear.
// The pipeline is a fold stage, one cell per CORDIC step (CORDIC_ITERATIONS,
// capped at 24), then four product stages. One request is accepted every
// cycle while the output side takes results. When the receiver stalls with
// a result waiting, the whole pipeline holds, empty stages included, and
// in_ready is low for as long as that result waits. Reset clears all stage
// valid flags; no results are pending after it.
// ----------------------------------------------------------------------------
module euler_zyx_to_rotation_matrix #(
  parameter int unsigned CORDIC_ITERATIONS = ezr_pkg::CORDIC_ITERS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  ezr_pkg::in_req_t   in_req,
  output logic               out_valid,
  input  logic               out_ready,
  output ezr_pkg::out_req_t  out_req
);
  import ezr_pkg::*;

  localparam int unsigned STEPS =
      (CORDIC_ITERATIONS > ATAN_ENTRIES) ? ATAN_ENTRIES : CORDIC_ITERATIONS;

  logic       en;
  cell_data_t fold_r;
  cell_data_t chain [STEPS+1];

  // Whole pipeline advances unless the final result is stuck.
  assign en       = !out_valid || out_ready;
  assign in_ready = en;

  function automatic lane_t fold(input logic signed [15:0] a);
    lane_t l;
    logic signed [ZW-1:0] z;
    z = ZW'(a) <<< 17;
    l.x = GAIN_Q30;
    l.y = '0;
    l.flip = 1'b0;
    if (z > HALF_PI_Q30) begin
      z = z - PI_Q30;
      l.flip = 1'b1;
    end else if (z < -HALF_PI_Q30) begin
      z = z + PI_Q30;
      l.flip = 1'b1;
    end
    l.z = z;
    return l;
  endfunction

  // Input stage: fold angles into the CORDIC range.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fold_r.vld <= 1'b0;
    end else if (en) begin
      fold_r.vld <= in_valid;
    end
    if (en) begin
      fold_r.ok    <= (in_req.order_code == ORDER_ZYX);
      fold_r.ln[0] <= fold(in_req.roll_angle);
      fold_r.ln[1] <= fold(in_req.pitch_angle);
      fold_r.ln[2] <= fold(in_req.yaw_angle);
    end
  end

  assign chain[0] = fold_r;

  // Chain of micro-rotation cells.
  for (genvar g = 0; g < STEPS; g++) begin : g_cell
    ezr_cell #(.STEP(g)) u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .en    (en),
      .d_in  (chain[g]),
      .d_out (chain[g+1])
    );
  end

  ezr_matrix u_matrix (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (en),
    .d_in  (chain[STEPS]),
    .vld   (out_valid),
    .res   (out_req)
  );

endmodule
